/* rtl/cross_neighbour_mean_filter_top_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the cross neighbour mean filter
// Shared property forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CROSS_NEIGHBOUR_MEAN_FILTER_TOP_DEFINES_SVH
`define CROSS_NEIGHBOUR_MEAN_FILTER_TOP_DEFINES_SVH

// condition must hold at every edge out of reset
`define CNMF_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CNMF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/cnmf_pkg.sv */
// ----------------------------------------------------------------------------
// cnmf_pkg
// Types and constants shared by the cross neighbour mean filter modules.
// ----------------------------------------------------------------------------
package cnmf_pkg;

   localparam int PIX_W          = 8;
   localparam int CFG_W          = 9;
   localparam int SUM_W          = 11;   // five 8-bit terms
   localparam int POS_OUT_W      = 8;
   localparam int CSR_IDX_W      = 1;
   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;

   localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 9'd256;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'd1;

   // floor(x/5) == (x*13108)>>16 for every x below 1276
   localparam int                  DIV5_MUL_W = 14;
   localparam logic [DIV5_MUL_W-1:0] DIV5_MUL = 14'd13108;
   localparam int                  DIV5_SHIFT = 16;

   // one line store entry: previous row and the row before it
   typedef struct packed {
      logic [PIX_W-1:0] above;
      logic [PIX_W-1:0] two_above;
   } line_word_type;

   // one column of the window
   typedef struct packed {
      logic [PIX_W-1:0] pix;
      logic [PIX_W-1:0] up;
      logic [PIX_W-1:0] up2;
   } column_type;

   typedef struct packed {
      logic [SUM_W-1:0]     sum;
      logic [POS_OUT_W-1:0] row;
      logic [POS_OUT_W-1:0] col;
      logic                 run_last;
      logic                 frame_last;
   } pend_type;

endpackage

/* rtl/cnmf_cell.sv */
// ----------------------------------------------------------------------------
// cnmf_cell
// One window column register: takes its neighbor's column on a step, or the
// column being written this cycle when the two refer to the same place.
// ----------------------------------------------------------------------------
module cnmf_cell import cnmf_pkg::*; (
   input  logic       clock,
   input  logic       en,
   input  logic       hit,
   input  column_type d,
   input  column_type hit_d,
   output column_type q
);

   column_type q_ff;
   column_type q_in;

   assign q_in = hit ? hit_d : d;

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff <= q_in;
      end
   end

   assign q = q_ff;

endmodule

/* rtl/cnmf_line_mem.sv */
// ----------------------------------------------------------------------------
// cnmf_line_mem
// Line store: one write and one registered read port per cycle.
// ----------------------------------------------------------------------------
module cnmf_line_mem import cnmf_pkg::*; #(
   parameter int DEPTH = DEF_MAX_WIDTH,
   parameter int AW    = $clog2(DEF_MAX_WIDTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  line_word_type wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output line_word_type rd_data
);

   line_word_type mem [DEPTH];
   line_word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read returns the contents before a write in the same cycle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/cross_neighbour_mean_filter_top.sv */
// ----------------------------------------------------------------------------
// cross_neighbour_mean_filter_top
// Five-point cross mean filter over a raster-order 8-bit gray frame.
// req_ takes one pixel word per cycle; rsp_ returns filtered words with
// tdata = {col, row, pixel}, tlast on the last word caused by a pixel and
// tuser on the final word of the frame. csr_ writes width (index 0) and
// height (index 1); csr_ready is always high.
// Output (i-1,j) comes with input (i,j); on the last row each pixel past
// column 0 also yields (H-1,j-1), and the final pixel adds (H-1,W-1).
// Throughput: one pixel per cycle while a pixel makes at most one word and
// rsp_tready is high; on the last row a pixel makes two words (the final one
// three), and req_tready stays low until the single rsp_ word register takes
// the last of them; each word waits in a pending slot before that register.
// After reset and every csr write, ST_PRIME_A and ST_PRIME_B prefetch the
// line store into the window (req_tready low); an out-of-range position
// restarts at 0,0. A stalled receiver fills the word register and the
// pending slots, and then req_tready drops until they drain.
// ----------------------------------------------------------------------------
`include "cross_neighbour_mean_filter_top_defines.svh"

module cross_neighbour_mean_filter_top import cnmf_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [7:0] pixel_in
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [23:0]          rsp_tdata,   // [7:0] pixel_out, [15:8] out_row, [23:16] out_col
   output logic                 rsp_tlast,
   output logic                 rsp_tuser,   // [0] frame_last
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data
);

   localparam int CW     = $clog2(MAX_WIDTH);
   localparam int RW     = $clog2(MAX_HEIGHT);
   localparam int WW     = CW + 1;
   localparam int HW     = RW + 1;
   localparam int PROD_W = SUM_W + DIV5_MUL_W;

   localparam logic [1:0] ST_PRIME_A = 2'd0;
   localparam logic [1:0] ST_PRIME_B = 2'd1;
   localparam logic [1:0] ST_RUN     = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [CFG_W-1:0] width_ff, width_in;
   logic [CFG_W-1:0] height_ff, height_in;
   logic [CW-1:0]    col_ff, col_in;
   logic [RW-1:0]    row_ff, row_in;
   logic [2:0]       pv_ff, pv_in;
   pend_type         pend_ff [3];
   pend_type         pend_in [3];
   logic             byp_ff, byp_in;
   line_word_type    byp_word_ff, byp_word_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [23:0]      rsp_data_ff;
   logic             rsp_last_ff;
   logic             rsp_user_ff;

   logic [WW-1:0]    w_eff;
   logic [HW-1:0]    h_eff;
   logic             w_is1;
   logic             restart;
   logic [CW-1:0]    col_start;
   logic [WW-1:0]    col_x;
   logic [WW-1:0]    t1;
   logic [WW-1:0]    t2;
   logic [CW-1:0]    rd_addr;
   logic             rd_en;
   line_word_type    rd_word;
   line_word_type    r_word;
   line_word_type    wr_word;
   logic             csr_acc;
   logic             accept;
   logic [7:0]       p;

   column_type       cur_q, prev_q, prev2_q;
   column_type       cur_d, cur_hit_d, prev_d;
   logic             cur_en;

   logic             last_row;
   logic             j_pos, j_ge2, j_next_in, j_end, i_pos, i_ge2, h_gt1;
   logic [2:0]       new_v;
   pend_type         res_a, res_b, res_c;
   logic [2:0]       pop_mask;
   logic             pop_en;
   pend_type         pop_item;
   logic [PROD_W-1:0] prod;

   // ---------------------------------------------------------------- config
   assign csr_ready = 1'b1;
   assign csr_acc   = csr_valid && csr_ready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_acc) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = csr_data;
            CSR_IMAGE_HEIGHT: height_in = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (width_ff == '0) w_eff = WW'(1);
      else if (32'(width_ff) > 32'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
      else w_eff = WW'(width_ff);
      if (height_ff == '0) h_eff = HW'(1);
      else if (32'(height_ff) > 32'(MAX_HEIGHT)) h_eff = HW'(MAX_HEIGHT);
      else h_eff = HW'(height_ff);
   end

   assign w_is1 = (w_eff == WW'(1));

   // -------------------------------------------------------------- position
   assign p     = req_tdata;
   assign col_x = {1'b0, col_ff};

   assign restart   = ({1'b0, row_ff} >= h_eff) || (col_x >= w_eff);
   assign col_start = restart ? '0 : col_ff;

   assign last_row  = ({1'b0, row_ff} == (h_eff - HW'(1)));
   assign i_pos     = (row_ff != '0);
   assign i_ge2     = ({1'b0, row_ff} >= HW'(2));
   assign j_pos     = (col_ff != '0);
   assign j_ge2     = (col_x >= WW'(2));
   assign j_next_in = ((col_x + WW'(1)) < w_eff);
   assign j_end     = (col_x == (w_eff - WW'(1)));
   assign h_gt1     = (h_eff != HW'(1));

   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      case (state_ff)
         ST_PRIME_A: begin
            state_in = ST_PRIME_B;
            if (restart) begin
               row_in = '0;
               col_in = '0;
            end
         end
         ST_PRIME_B: state_in = ST_RUN;
         ST_RUN: begin
            if (accept) begin
               if (!j_next_in) begin
                  col_in = '0;
                  row_in = (({1'b0, row_ff} + HW'(1)) >= h_eff) ? '0 : row_ff + RW'(1);
               end else begin
                  col_in = col_ff + CW'(1);
               end
            end
         end
         default: state_in = ST_PRIME_A;
      endcase
      if (csr_acc) begin
         state_in = ST_PRIME_A;
      end
   end

   // ------------------------------------------------------------ line store
   // prefetch runs two columns ahead; the bypass covers narrow frames where
   // the column read is the one written in the same cycle
   assign t1 = col_x + WW'(1);
   assign t2 = col_x + WW'(2);

   always_comb begin
      rd_addr = '0;
      case (state_ff)
         ST_PRIME_A: rd_addr = col_start;
         ST_PRIME_B: rd_addr = (t1 >= w_eff) ? '0 : t1[CW-1:0];
         ST_RUN: begin
            if (w_is1) rd_addr = '0;
            else if (t2 >= w_eff) rd_addr = CW'(t2 - w_eff);
            else rd_addr = t2[CW-1:0];
         end
         default: rd_addr = '0;
      endcase
   end

   assign rd_en = (state_ff == ST_PRIME_A) || (state_ff == ST_PRIME_B) || accept;

   assign wr_word.above     = p;
   assign wr_word.two_above = cur_q.up;

   cnmf_line_mem #(
      .DEPTH (MAX_WIDTH),
      .AW    (CW)
   ) u_line_mem (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_ff),
      .wr_data (wr_word),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   always_comb begin
      byp_in      = byp_ff;
      byp_word_in = byp_word_ff;
      if (accept) begin
         byp_in      = (rd_addr == col_ff);
         byp_word_in = wr_word;
      end else if (state_ff != ST_RUN) begin
         byp_in = 1'b0;
      end
   end

   assign r_word = byp_ff ? byp_word_ff : rd_word;

   // ---------------------------------------------------------- window cells
   assign cur_en        = accept || (state_ff == ST_PRIME_B);
   assign cur_d.pix     = '0;
   assign cur_d.up      = r_word.above;
   assign cur_d.up2     = r_word.two_above;
   assign cur_hit_d.pix = '0;
   assign cur_hit_d.up  = p;
   assign cur_hit_d.up2 = cur_q.up;
   assign prev_d.pix    = p;
   assign prev_d.up     = cur_q.up;
   assign prev_d.up2    = cur_q.up2;

   cnmf_cell u_cell_cur (
      .clock (clock),
      .en    (cur_en),
      .hit   (accept && w_is1),
      .d     (cur_d),
      .hit_d (cur_hit_d),
      .q     (cur_q)
   );

   cnmf_cell u_cell_prev (
      .clock (clock),
      .en    (accept),
      .hit   (1'b0),
      .d     (prev_d),
      .hit_d (cur_q),
      .q     (prev_q)
   );

   cnmf_cell u_cell_prev2 (
      .clock (clock),
      .en    (accept),
      .hit   (1'b0),
      .d     (prev_q),
      .hit_d (prev_q),
      .q     (prev2_q)
   );

   // ------------------------------------------------------------ cross sums
   // prev_q.up is the row above at column j-1, already rotated into the
   // older line; cur_q is column j, r_word column j+1
   assign new_v[0] = i_pos;
   assign new_v[1] = last_row && j_pos;
   assign new_v[2] = last_row && j_end;

   always_comb begin
      res_a.sum = SUM_W'(cur_q.up) + SUM_W'(p)
                + (i_ge2     ? SUM_W'(cur_q.up2)    : '0)
                + (j_pos     ? SUM_W'(prev_q.up)    : '0)
                + (j_next_in ? SUM_W'(r_word.above) : '0);
      res_a.row        = POS_OUT_W'(row_ff - RW'(1));
      res_a.col        = POS_OUT_W'(col_ff);
      res_a.run_last   = !(new_v[1] || new_v[2]);
      res_a.frame_last = 1'b0;

      res_b.sum = SUM_W'(prev_q.pix) + SUM_W'(p)
                + (j_ge2 ? SUM_W'(prev2_q.pix) : '0)
                + (h_gt1 ? SUM_W'(prev_q.up)   : '0);
      res_b.row        = POS_OUT_W'(row_ff);
      res_b.col        = POS_OUT_W'(col_ff - CW'(1));
      res_b.run_last   = !new_v[2];
      res_b.frame_last = 1'b0;

      res_c.sum = SUM_W'(p)
                + (j_pos ? SUM_W'(prev_q.pix) : '0)
                + (h_gt1 ? SUM_W'(cur_q.up)   : '0);
      res_c.row        = POS_OUT_W'(row_ff);
      res_c.col        = POS_OUT_W'(col_ff);
      res_c.run_last   = 1'b1;
      res_c.frame_last = 1'b1;
   end

   // ---------------------------------------------------- pending and output
   always_comb begin
      if (pv_ff[0]) begin
         pop_mask = 3'b001;
         pop_item = pend_ff[0];
      end else if (pv_ff[1]) begin
         pop_mask = 3'b010;
         pop_item = pend_ff[1];
      end else begin
         pop_mask = {pv_ff[2], 2'b00};
         pop_item = pend_ff[2];
      end
   end

   assign pop_en     = (pv_ff != '0) && (!rsp_valid_ff || rsp_tready);
   assign req_tready = (state_ff == ST_RUN) && ((pv_ff & ~(pop_en ? pop_mask : 3'b000)) == '0);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      pv_in      = pv_ff & ~(pop_en ? pop_mask : 3'b000);
      pend_in[0] = pend_ff[0];
      pend_in[1] = pend_ff[1];
      pend_in[2] = pend_ff[2];
      if (accept) begin
         pv_in      = new_v;
         pend_in[0] = res_a;
         pend_in[1] = res_b;
         pend_in[2] = res_c;
      end
   end

   assign prod = PROD_W'(pop_item.sum) * PROD_W'(DIV5_MUL);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop_en) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_PRIME_A;
         width_ff     <= CFG_SIZE_RESET;
         height_ff    <= CFG_SIZE_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         pv_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff[0]  <= pend_in[0];
      pend_ff[1]  <= pend_in[1];
      pend_ff[2]  <= pend_in[2];
      byp_ff      <= byp_in;
      byp_word_ff <= byp_word_in;
      if (pop_en) begin
         rsp_data_ff <= {pop_item.col, pop_item.row, prod[DIV5_SHIFT +: PIX_W]};
         rsp_last_ff <= pop_item.run_last;
         rsp_user_ff <= pop_item.frame_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

   // ------------------------------------------------------------ assertions
   `CNMF_ASSERT_NEXT(a_pend_drains, pv_ff != '0, rsp_valid_ff, "pending word not presented")
   `CNMF_ASSERT_ALWAYS(a_frame_last, !(rsp_tvalid && rsp_tuser) || rsp_tlast, "frame end without tlast")
   `CNMF_ASSERT_NEXT(a_csr_primes, csr_acc, !req_tready, "pixel taken during prefetch")
   `CNMF_ASSERT_ALWAYS(a_pos_range, state_ff != ST_RUN || (!restart), "position outside frame")

endmodule

/* bench/cnmf_word_checker.sv */
// ----------------------------------------------------------------------------
// cnmf_word_checker
// Watches the pixel, filtered word and csr channels of the cross mean filter.
// Keeps its own copy of the line stores, the left pixels, the raster position
// and the frame size, works out the filtered words that every accepted pixel
// causes and compares each accepted rsp_ word with the oldest one due.
// ----------------------------------------------------------------------------
module cnmf_word_checker import cnmf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [7:0]           req_tdata,
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [23:0]          rsp_tdata,
   input  logic                 rsp_tlast,
   input  logic                 rsp_tuser,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data,
   output int                   mismatch_count,
   output int                   words_due
);

   localparam int CROSS_TERMS = 5;

   typedef struct packed {
      logic [PIX_W-1:0]     pix;
      logic [POS_OUT_W-1:0] row;
      logic [POS_OUT_W-1:0] col;
      logic                 run_last;
      logic                 frame_last;
   } filtered_word_t;

   logic [PIX_W-1:0] above_line     [0:DEF_MAX_WIDTH-1];
   logic [PIX_W-1:0] two_above_line [0:DEF_MAX_WIDTH-1];
   logic [PIX_W-1:0] left_pix;
   logic [PIX_W-1:0] second_left_pix;
   int               row_pos;
   int               col_pos;
   logic [CFG_W-1:0] cfg_width;
   logic [CFG_W-1:0] cfg_height;
   filtered_word_t   filtered_due [$];
   filtered_word_t   seen;
   filtered_word_t   want;
   int               entry;

   function automatic int usable_size(input logic [CFG_W-1:0] v, input int limit);
      if (v == 0) return 1;
      if (v > limit) return limit;
      return v;
   endfunction

   function automatic filtered_word_t make_word(input int sum, input int r, input int c);
      filtered_word_t fw;
      fw.pix        = sum / CROSS_TERMS;
      fw.row        = r[POS_OUT_W-1:0];
      fw.col        = c[POS_OUT_W-1:0];
      fw.run_last   = 1'b0;
      fw.frame_last = 1'b0;
      return fw;
   endfunction

   // words caused by one pixel, in the order (i-1,j), (H-1,j-1), (H-1,W-1)
   task automatic predict_words(input logic [PIX_W-1:0] p);
      int               w, h, i, j, sum, cnt;
      logic             last_row;
      logic [PIX_W-1:0] a, b;
      filtered_word_t   fresh [0:2];
      w   = usable_size(cfg_width, DEF_MAX_WIDTH);
      h   = usable_size(cfg_height, DEF_MAX_HEIGHT);
      cnt = 0;
      if (row_pos >= h || col_pos >= w) begin
         row_pos = 0;
         col_pos = 0;
      end
      i        = row_pos;
      j        = col_pos;
      last_row = (i == h - 1);
      a        = above_line[j];
      b        = two_above_line[j];
      if (i >= 1) begin
         sum = a + p;
         if (i >= 2) sum += b;
         if (j > 0) sum += two_above_line[j-1];
         if (j + 1 < w) sum += above_line[j+1];
         fresh[cnt] = make_word(sum, i - 1, j);
         cnt++;
      end
      two_above_line[j] = a;
      above_line[j]     = p;
      if (last_row && j >= 1) begin
         sum = left_pix + p;
         if (j >= 2) sum += second_left_pix;
         if (h > 1) sum += two_above_line[j-1];
         fresh[cnt] = make_word(sum, i, j - 1);
         cnt++;
      end
      if (last_row && j == w - 1) begin
         sum = p;
         if (j >= 1) sum += left_pix;
         if (h > 1) sum += a;
         fresh[cnt] = make_word(sum, i, j);
         fresh[cnt].frame_last = 1'b1;
         cnt++;
      end
      if (cnt > 0) fresh[cnt-1].run_last = 1'b1;
      for (int k = 0; k < cnt; k++) filtered_due.push_back(fresh[k]);
      second_left_pix = left_pix;
      left_pix        = p;
      if (j + 1 >= w) begin
         col_pos = 0;
         row_pos = (i + 1 >= h) ? 0 : i + 1;
      end else begin
         col_pos = j + 1;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (entry = 0; entry < DEF_MAX_WIDTH; entry++) begin
            above_line[entry]     = '0;
            two_above_line[entry] = '0;
         end
         left_pix        = '0;
         second_left_pix = '0;
         row_pos         = 0;
         col_pos         = 0;
         cfg_width       = CFG_SIZE_RESET;
         cfg_height      = CFG_SIZE_RESET;
         filtered_due.delete();
         mismatch_count  = 0;
         words_due       = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_IMAGE_WIDTH) cfg_width = csr_data;
            else cfg_height = csr_data;
         end
         if (rsp_tvalid && rsp_tready) begin
            seen.pix        = rsp_tdata[7:0];
            seen.row        = rsp_tdata[15:8];
            seen.col        = rsp_tdata[23:16];
            seen.run_last   = rsp_tlast;
            seen.frame_last = rsp_tuser;
            if (filtered_due.size() == 0) begin
               $display("%0t unexpected word: pix %0d row %0d col %0d last %0b frame %0b",
                        $time, seen.pix, seen.row, seen.col, seen.run_last, seen.frame_last);
               mismatch_count++;
            end else begin
               want = filtered_due.pop_front();
               if (seen !== want) begin
                  $display("%0t word mismatch: expected pix %0d row %0d col %0d last %0b frame %0b",
                           $time, want.pix, want.row, want.col, want.run_last,
                           want.frame_last);
                  $display("%0t                  actual pix %0d row %0d col %0d last %0b frame %0b",
                           $time, seen.pix, seen.row, seen.col, seen.run_last,
                           seen.frame_last);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready) predict_words(req_tdata);
         words_due = filtered_due.size();
      end
   end

endmodule

/* bench/tb_cross_neighbour_mean_filter_top.sv */
// ----------------------------------------------------------------------------
// tb_cross_neighbour_mean_filter_top
// Streams gray frames into the cross mean filter: reset size, out-of-range
// sizes, the widest and tallest frames, saturated and dark frames, height
// changed inside a frame, restarts forced by shrinking the size, and random
// small frames. Both sides idle at random; word_check does the comparing.
// ----------------------------------------------------------------------------
module tb_cross_neighbour_mean_filter_top;
   import cnmf_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_ITEMS  = 170;
   localparam int MAX_WAIT      = 14;

   typedef enum {FILL_RANDOM, FILL_BRIGHT, FILL_DARK, FILL_MIXED} fill_kind_t;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [7:0]           req_tdata;   // [7:0] pixel_in
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [23:0]          rsp_tdata;   // [7:0] pixel_out, [15:8] out_row, [23:16] out_col
   logic                 rsp_tlast;
   logic                 rsp_tuser;   // [0] frame_last
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_data;

   int mismatch_count;
   int words_due;
   int cycle_count;
   bit req_gaps;
   bit rsp_stalls;
   int cur_w;
   int cur_h;

   cross_neighbour_mean_filter_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   cnmf_word_checker word_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .rsp_tuser      (rsp_tuser),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .words_due      (words_due)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_cross_neighbour_mean_filter_top: FAIL");
         $finish;
      end
   end

   // receiver: while rsp_stalls is set, hold tready low after every word for a drawn number of cycles
   initial begin : rsp_side
      int hold;
      rsp_tready = 1'b0;
      hold       = 0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            hold = hold - 1;
         end else begin
            rsp_tready <= 1'b1;
         end
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) hold = rsp_stalls ? $urandom_range(0, MAX_WAIT) : 0;
      end
   end

   function automatic int usable_size(input logic [CFG_W-1:0] v, input int limit);
      if (v == 0) return 1;
      if (v > limit) return limit;
      return v;
   endfunction

   function automatic logic [7:0] pick_pixel(input fill_kind_t kind);
      case (kind)
         FILL_BRIGHT: return 8'hFF;
         FILL_DARK:   return 8'h00;
         FILL_MIXED: begin
            if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            return $urandom_range(0, 255);
         end
         default:     return $urandom_range(0, 255);
      endcase
   endfunction

   task automatic set_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
      if (idx == CSR_IMAGE_WIDTH) cur_w = usable_size(val, DEF_MAX_WIDTH);
      else cur_h = usable_size(val, DEF_MAX_HEIGHT);
   endtask

   task automatic set_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
      set_reg(CSR_IMAGE_WIDTH, w);
      set_reg(CSR_IMAGE_HEIGHT, h);
   endtask

   task automatic feed(input int count, input fill_kind_t kind);
      int gap;
      int n;
      for (n = 0; n < count; n++) begin
         gap = req_gaps ? $urandom_range(0, MAX_WAIT) : 0;
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= pick_pixel(kind);
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         @(negedge clock);
      end
   endtask

   // row 0 pixels make no word unless the frame is one row high, so also settle after the queue drains
   task automatic quiesce;
      req_tvalid <= 1'b0;
      while (words_due != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      req_gaps   = ($urandom_range(0, 3) != 0);
      rsp_stalls = ($urandom_range(0, 3) != 0);
   endtask

   initial begin : stimulus
      int random_sent;
      int cut;
      int frames;
      int w_pick;
      int h_pick;
      fill_kind_t kind;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_valid   = 1'b0;
      csr_index   = CSR_IMAGE_WIDTH;
      csr_data    = '0;
      req_gaps    = 1'b0;
      rsp_stalls  = 1'b0;
      cycle_count = 0;
      cur_w       = DEF_MAX_WIDTH;
      cur_h       = DEF_MAX_HEIGHT;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // reset size: full first row, then the start of the second
      feed(2, FILL_BRIGHT);
      feed(2, FILL_DARK);
      feed(DEF_MAX_WIDTH - 4, FILL_MIXED);
      feed(4, FILL_RANDOM);
      quiesce;

      // zero sizes act as 1x1; the held position is outside, so restart
      set_size(0, 0);
      feed(1, FILL_BRIGHT);
      feed(1, FILL_DARK);
      feed(1, FILL_RANDOM);
      quiesce;

      set_size(3, 3);
      feed(9, FILL_BRIGHT);
      quiesce;
      set_size(2, 2);
      feed(4, FILL_MIXED);
      quiesce;

      // height cut inside a frame: row 2 turns into the last row
      set_size(4, 6);
      feed(10, FILL_RANDOM);
      quiesce;
      set_reg(CSR_IMAGE_HEIGHT, 3);
      feed(2, FILL_RANDOM);
      quiesce;
      // width cut below the held column restarts the frame
      feed(5, FILL_RANDOM);
      quiesce;
      set_reg(CSR_IMAGE_WIDTH, 1);
      feed(3, FILL_RANDOM);
      quiesce;

      // oversize values clamp to the widest row and the tallest column
      set_size(9'h1FF, 1);
      feed(cur_w, FILL_MIXED);
      quiesce;
      set_size(1, 9'h1FF);
      feed(cur_h, FILL_MIXED);
      quiesce;

      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         w_pick = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 6);
         h_pick = $urandom_range(1, 6);
         case ($urandom_range(0, 2))
            0:       set_size(w_pick, h_pick);
            1:       set_reg(CSR_IMAGE_WIDTH, w_pick);
            default: set_reg(CSR_IMAGE_HEIGHT, h_pick);
         endcase
         frames = $urandom_range(1, 2);
         repeat (frames) begin
            kind = ($urandom_range(0, 1) != 0) ? FILL_MIXED : FILL_RANDOM;
            feed(cur_w * cur_h, kind);
            random_sent += cur_w * cur_h;
         end
         if (cur_w * cur_h > 1 && $urandom_range(0, 4) == 0) begin
            cut = $urandom_range(1, cur_w * cur_h - 1);
            feed(cut, FILL_RANDOM);
            random_sent += cut;
            quiesce;
            // shrink so the held position falls outside, then one clean frame
            if (cut / cur_w >= 1) set_reg(CSR_IMAGE_HEIGHT, cut / cur_w);
            else set_reg(CSR_IMAGE_WIDTH, cut);
            feed(cur_w * cur_h, FILL_MIXED);
            random_sent += cur_w * cur_h;
         end
         quiesce;
      end

      if (mismatch_count == 0) begin
         $display("tb_cross_neighbour_mean_filter_top: PASS");
      end else begin
         $display("tb_cross_neighbour_mean_filter_top: FAIL");
      end
      $finish;
   end

endmodule
